[design/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Holds the default sizes, the configuration reset value, the controller
// state encoding and the command and status groups between the two modules.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 31;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 5;
  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = CFG_BITS'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the request's sample, write it into the ring
    logic insert;   // insert the sample into the sorted row, read the oldest
    logic emit;     // load the median into the output register, drop oldest
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_full;  // this sample completes the window
    logic out_busy;     // output register holds a result that is stalled
  } status_t;

endpackage

[design/swm_ctrl.sv]
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding window median filter
// Walks each request through capture, sorted insert and, when the window is
// full, the median hand-off to the output register.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  swm_pkg::status_t stat,
  output swm_pkg::cmd_t    cmd
);

  swm_pkg::state_t state_r;
  swm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = swm_pkg::ST_INSERT;
        end
      end
      swm_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = stat.window_full ? swm_pkg::ST_EMIT : swm_pkg::ST_IDLE;
      end
      swm_pkg::ST_EMIT: begin
        // Wait until the output register can take the result.
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::ST_IDLE;
      end
    endcase
  end

  a_emit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swm_pkg::ST_EMIT && !stat.out_busy) |=> (state_r == swm_pkg::ST_IDLE))
    else $error("emit state did not return to idle");

  a_insert_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.insert)
    else $error("captured sample was not inserted in the next cycle");

endmodule

[design/swm_datapath.sv]
// ----------------------------------------------------------------------------
// swm_datapath: storage and compare logic of the sliding window median filter
// Holds the history ring memory, the sorted row of cells, the fill count,
// the ring pointer, the window size register and the output register.
// ----------------------------------------------------------------------------
module swm_datapath #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::cmd_t                 cmd,
  output swm_pkg::status_t              stat,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_median
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW    = (CNT_W > swm_pkg::CFG_BITS) ? CNT_W : swm_pkg::CFG_BITS;

  logic [swm_pkg::CFG_BITS-1:0]  wsize_r;
  logic [CNT_W-1:0]              fill_r;
  logic [CNT_W-1:0]              rp_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic                          out_valid_r;

  logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] sorted_r [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] ins_row  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rem_row  [WINDOW_MAX];

  logic [KW-1:0]    wsize_ext;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rp_next;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] k_m1;
  logic [WINDOW_MAX-1:0] ins_mark;

  // Effective window size: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    wsize_ext = KW'(wsize_r);
    if (wsize_ext == '0) begin
      k = CNT_W'(1);
    end else if (wsize_ext > KW'(WINDOW_MAX)) begin
      k = CNT_W'(WINDOW_MAX);
    end else begin
      k = CNT_W'(wsize_ext);
    end
    k_m1    = k - CNT_W'(1);
    cnt     = (fill_r > k_m1) ? k_m1 : fill_r;
    rp_next = (rp_r == k_m1) ? '0 : rp_r + CNT_W'(1);
    mid     = k_m1 >> 1;
  end

  assign stat.window_full = (cnt == k_m1);
  assign stat.out_busy    = out_valid_r && out_stall;

  // Insert: every cell at or past the insertion point takes its lower
  // neighbor; the first such cell takes the new sample.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      ins_mark[i] = ((CNT_W'(i) < cnt) && (sorted_r[i] > samp_r)) || (CNT_W'(i) == cnt);
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      ins_row[i] = sorted_r[i];
      if (CNT_W'(i) <= cnt) begin
        if (i > 0 && ins_mark[(i > 0) ? i - 1 : 0]) begin
          ins_row[i] = sorted_r[(i > 0) ? i - 1 : 0];
        end else if (ins_mark[i]) begin
          ins_row[i] = samp_r;
        end
      end
    end
  end

  // Remove: the row is sorted and holds the oldest sample, so every cell
  // from its first copy onward takes its upper neighbor.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      rem_row[i] = sorted_r[i];
      if (i < WINDOW_MAX - 1 && CNT_W'(i) < k_m1 && sorted_r[i] >= old_r) begin
        rem_row[i] = sorted_r[(i < WINDOW_MAX - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ring_mem[rp_r[AW-1:0]] <= in_sample;
    end
    if (cmd.insert) begin
      old_r <= ring_mem[rp_next[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_r <= in_sample;
    end
    if (cmd.insert) begin
      sorted_r <= ins_row;
    end else if (cmd.emit) begin
      sorted_r <= rem_row;
    end
    if (cmd.emit) begin
      out_r <= sorted_r[mid[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r     <= swm_pkg::WINDOW_SIZE_RST;
      fill_r      <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wsize_r <= cfg_wr_data;
        fill_r  <= '0;
        rp_r    <= '0;
      end else if (cmd.insert) begin
        fill_r <= stat.window_full ? cnt : cnt + CNT_W'(1);
        rp_r   <= rp_next;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("median loaded over a stalled result");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < k)
    else $error("fill count reached the window size");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r < k)
    else $error("ring pointer outside the window");

endmodule

[design/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the last window_size samples
// Keeps recent samples in a ring memory and in a sorted row of cells, and
// reports the lower median of each full window.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-------------------------------
//   input    | in_valid, in_stall, in_sample  | one signed sample per request
//   result   | out_valid, out_stall, out_median | one median per full window
//   config   | cfg_wr_en, cfg_wr_data         | window size, 1..31 effective
//
// A request passes through capture and one sorted insert across all cells,
// and, when it yields a median, the median load with removal of the oldest
// sample. The sorted row and the single ring port set these steps. Reset is
// synchronous and active low; it sets the window size to three and empties
// the window. A stalled result sits in the output register while the next
// request is captured and inserted; only the median load waits for the
// register to drain. Writing the window size empties the window.
//
module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_median,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  swm_pkg::cmd_t    cmd;
  swm_pkg::status_t stat;

  // Sequencer: one request at a time through capture, insert and emit.
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring memory, sorted cells and the output register.
  swm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_sample   (in_sample),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_median  (out_median)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_result_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result shown without a median load");

endmodule

[test/tb_sliding_window_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median: self-checking bench for the running median filter
// Sends signed samples through the valid/stall request channel, predicts each
// lower median with a ring and a sorted window of its own, and compares every
// result against the oldest pending prediction. A directed table opens the
// run; random phases over many window sizes, idles and stalls follow.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

  localparam int SB   = swm_pkg::SAMPLE_BITS_DEF;
  localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
  localparam int CB   = swm_pkg::CFG_BITS;

  // With no median owed, a request in the block has only its insert left,
  // so quiet cycles are plenty before a register write or the final verdict.
  localparam int SETTLE_CYCLES   = 12;
  localparam int TAIL_CYCLES     = 16;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES     = 200;
  // Cycles without any accepted request, result or write before giving up.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASE_COUNT     = 12;
  localparam int ITEMS_PER_PHASE = 54;
  // Marks a random phase whose window size is drawn at run time.
  localparam int RANDOM_SIZE     = -1;

  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_CONFIG
  } row_kind_t;

  // One row of the directed table. For a sample row, typed marks a median that
  // is plain from the window contents and is queued as written here; other
  // rows take the predicted value. For a config row, value holds the size.
  typedef struct packed {
    row_kind_t       kind;
    logic [SB-1:0]   value;
    logic            typed;
    logic [SB-1:0]   median;
  } vector_t;

  localparam int DIRECTED_ROWS = 24;
  localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
    // Reset size of three: extremes first, then equal samples, then sign
    // crossings. The first two requests only fill the window.
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 16'h0005, 1'b1, 16'h0005},
    '{ROW_SAMPLE, 16'h0005, 1'b1, 16'h0005},
    '{ROW_SAMPLE, 16'h0005, 1'b1, 16'h0005},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'h0005},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 16'h0000},
    // A size of one returns every sample unchanged.
    '{ROW_CONFIG, 16'd1,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
    // A size of zero behaves as a size of one.
    '{ROW_CONFIG, 16'd0,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0007, 1'b1, 16'h0007},
    // An even size reports the lower of the two middle values.
    '{ROW_CONFIG, 16'd2,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h000A, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFFF6, 1'b1, 16'hFFF6},
    '{ROW_SAMPLE, 16'h0014, 1'b1, 16'hFFF6},
    // The largest size, left half full so that the next write has to empty it.
    '{ROW_CONFIG, 16'd31,   1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0002, 1'b0, 16'h0000}
  };

  // Window sizes of the random phases; both ends of the register range appear.
  localparam int PHASE_SIZE [PHASE_COUNT] = '{
    31, 4, 1, 2, 0, 17, 30, RANDOM_SIZE, RANDOM_SIZE, 8, 31, 3
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SB-1:0] in_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SB-1:0] out_median;
  logic                 cfg_wr_en;
  logic [CB-1:0]        cfg_wr_data;

  sliding_window_median dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_median  (out_median),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Medians that the accepted requests still owe, oldest first.
  logic signed [SB-1:0] medians_due [$];

  // The filter state as this bench sees it: the window size register, the
  // samples in arrival order, the same samples sorted, how many are held and
  // where the next one goes.
  logic [CB-1:0]        win_reg;
  logic signed [SB-1:0] ring_mem   [WMAX];
  logic signed [SB-1:0] sorted_mem [WMAX];
  int unsigned          held;
  int unsigned          wr_ptr;

  int errors;
  int samples_sent;
  int medians_seen;
  int settings_used;

  // Traffic shaping: calm turns off all idling on both sides, squeeze asks the
  // receiver for its one long hold-off.
  bit calm;
  bit squeeze;
  bit squeezed;

  function automatic int unsigned active_size();
    int unsigned k;
    k = (win_reg == '0) ? 1 : win_reg;
    if (k > WMAX) k = WMAX;
    return k;
  endfunction

  // Takes one sample into the window. Returns 1 with the lower median when the
  // sample completes the window; the oldest sample then leaves the sorted copy,
  // one entry only when several are equal, and the next sample takes its slot.
  function automatic bit step_window(input logic signed [SB-1:0] v,
                                     output logic signed [SB-1:0] med);
    int unsigned k;
    int unsigned slot;
    int unsigned nxt;
    int unsigned i;
    logic signed [SB-1:0] oldest;
    k    = active_size();
    slot = wr_ptr % k;
    nxt  = (slot + 1) % k;
    med  = '0;
    if (held >= k) held = k - 1;
    ring_mem[slot] = v;
    i = held;
    while (i > 0 && sorted_mem[i-1] > v) begin
      sorted_mem[i] = sorted_mem[i-1];
      i--;
    end
    sorted_mem[i] = v;
    if (held + 1 < k) begin
      held++;
      wr_ptr = nxt;
      return 1'b0;
    end
    med    = sorted_mem[(k - 1) / 2];
    oldest = ring_mem[nxt];
    i = 0;
    while (i < k && sorted_mem[i] != oldest) i++;
    if (i < k) begin
      while (i + 1 < k) begin
        sorted_mem[i] = sorted_mem[i+1];
        i++;
      end
    end
    wr_ptr = nxt;
    return 1'b1;
  endfunction

  // Gap before a request: mostly none, often a few cycles, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Sample values: half fully random, many small ones so that equal samples
  // crowd the window, and the odd extreme.
  function automatic logic [SB-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return SB'($urandom);
    if (r < 8) return SB'(int'($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 3))
      0:       return {1'b0, {(SB-1){1'b1}}};
      1:       return {1'b1, {(SB-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Offers one request and holds it until accepted, then predicts its median.
  // Called right after a rising edge; in_valid gets at most one update per
  // step, so a back-to-back request keeps valid high without a glitch.
  task automatic offer_sample(input logic [SB-1:0] v, input logic typed,
                              input logic [SB-1:0] typed_med);
    int unsigned gap;
    logic signed [SB-1:0] med;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (step_window($signed(v), med)) begin
      medians_due.insert(medians_due.size(), typed ? $signed(typed_med) : med);
    end
  endtask

  // Writes the window size once the block has gone quiet. A request that only
  // fills the window leaves no result behind, so an empty queue alone does not
  // prove the block idle; the settle time covers that last request.
  task automatic write_window(input logic [CB-1:0] size);
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= size;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    win_reg = size;
    held    = 0;
    wr_ptr  = 0;
    settings_used++;
  endtask

  // Result side: checks each accepted median and shapes out_stall. Stall runs
  // and free runs alternate, with the one long hold-off when asked for.
  initial begin
    int unsigned run_left;
    int unsigned hold_left;
    bit stall_now;
    logic signed [SB-1:0] want;
    run_left  = 0;
    hold_left = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          $error("median: no result expected, got %0d", out_median);
          errors++;
        end else begin
          want = medians_due.pop_front();
          if (out_median !== want) begin
            $error("median: expected %0d, got %0d", want, out_median);
            errors++;
          end
          medians_seen++;
        end
      end
      if (squeeze && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (calm) begin
        stall_now = 1'b0;
        run_left  = 0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 1) == 0);
          if (!stall_now) run_left = $urandom_range(1, 30);
          else if ($urandom_range(0, 9) < 8) run_left = $urandom_range(1, 3);
          else run_left = $urandom_range(4, 20);
        end
        run_left--;
      end
      out_stall <= stall_now;
    end
  end

  // Watchdog: any accepted request, result or register write counts as
  // progress; a long stretch without any means the block has hung.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    vector_t row;
    int size;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_sample   <= '0;
    out_stall   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    errors        = 0;
    samples_sent  = 0;
    medians_seen  = 0;
    settings_used = 0;
    calm          = 1'b0;
    squeeze       = 1'b0;
    squeezed      = 1'b0;
    win_reg       = swm_pkg::WINDOW_SIZE_RST;
    held          = 0;
    wr_ptr        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CONFIG) write_window(row.value[CB-1:0]);
      else offer_sample(row.value, row.typed, row.median);
    end

    // Each phase opens with a size write, which also throws away whatever the
    // previous phase left half filled. Any size-four phase runs with no idling
    // at all; the first size-one phase carries the long receiver hold-off, so the
    // block fills up and pushes back on its input.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      size = (PHASE_SIZE[p] == RANDOM_SIZE) ? $urandom_range(0, 31) : PHASE_SIZE[p];
      write_window(CB'(size));
      calm    = (size == 4);
      squeeze = (size == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_sample(pick_sample(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d samples in, %0d medians checked, %0d window size writes",
             samples_sent, medians_seen, settings_used);
    $display("summary: sizes 0 to 31 with equal samples, extremes and a long output hold");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
design/swm_pkg.sv
design/swm_ctrl.sv
design/swm_datapath.sv
design/sliding_window_median.sv
test/tb_sliding_window_median.sv
